### rtl/base32_token_decoder_macros.svh
// Assertion macros for the base32 token decoder.
// Used by base32_token_decoder.sv; no other dependencies.
`ifndef BASE32_TOKEN_DECODER_MACROS_SVH
`define BASE32_TOKEN_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define B32TD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b32td: assertion failed");
// next-cycle implication, disabled in reset
`define B32TD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b32td: assertion failed");
`else
`define B32TD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define B32TD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/b32td_pkg.sv
// Package for the base32 token decoder: sizes, status and register codes,
// and the Crockford symbol decode. No dependencies.
`timescale 1ns / 1ps

package b32td_pkg;

    localparam int MAC_WIDTH    = 20;
    localparam int PAYLOAD_BITS = 60;
    localparam int TOKEN_BITS   = PAYLOAD_BITS + MAC_WIDTH;
    localparam int SYMBOLS      = TOKEN_BITS / 5;
    localparam int CNT_W        = $clog2(SYMBOLS + 1);
    localparam int OUT_BITS     = 63 + MAC_WIDTH;
    localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [3:0] TOKEN_VERSION = 4'd1;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_CODE      = 3'd1,
        ST_BAD_VERSION   = 3'd2,
        ST_BAD_ACTION    = 3'd3,
        ST_WRONG_DATE    = 3'd4,
        ST_MINUTES_LIMIT = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_CURRENT_DAY   = 2'd0,
        CFG_MAX_ADD_MIN   = 2'd1,
        CFG_TOKEN_MAX_MIN = 2'd2,
        CFG_ACCEPT_ACTION = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic       valid;
        logic [4:0] value;
    } t_sym;

    // Crockford base32, case-insensitive; O reads as 0, I and L as 1, U is invalid
    function automatic t_sym sym_decode(input logic [7:0] c);
        logic [7:0] uc;
        t_sym       s;
        uc = c;
        if (c inside {[8'h61:8'h7a]}) begin
            uc = c - 8'd32;
        end
        s.valid = 1'b1;
        s.value = 5'd0;
        case (uc) inside
            [8'h30:8'h39]: s.value = 5'(uc - 8'h30);
            8'h4f:         s.value = 5'd0;
            8'h49, 8'h4c:  s.value = 5'd1;
            [8'h41:8'h48]: s.value = 5'(uc - 8'h41 + 8'd10);
            [8'h4a:8'h4b]: s.value = 5'(uc - 8'h4a + 8'd18);
            [8'h4d:8'h4e]: s.value = 5'(uc - 8'h4d + 8'd20);
            [8'h50:8'h54]: s.value = 5'(uc - 8'h50 + 8'd22);
            [8'h56:8'h5a]: s.value = 5'(uc - 8'h56 + 8'd27);
            default:       s.valid = 1'b0;
        endcase
        return s;
    endfunction

endpackage

### rtl/base32_token_decoder.sv
// Base32 token decoder top level: character accumulation, token checks,
// config registers. Depends on b32td_pkg and base32_token_decoder_macros.svh.
`timescale 1ns / 1ps
`include "base32_token_decoder_macros.svh"

// Takes a token one character per word on the slave stream, skips separators
// ('-', space, tab, CR, LF), decodes Crockford base32 symbols into an 80-bit
// shift register, and on the word with tlast set emits one status word on the
// master stream with the unpacked version, action, minutes, day, nonce and the
// raw (unverified) MAC. A character is taken every cycle while s_axis_tready
// is high; the result passes through a snapshot stage, then the output register
// that holds the checks. Backpressure on the master side stalls input only when
// a finished token is waiting in the snapshot stage and the output is stalled.
// Config registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and must
// only change while no token result is pending.
module base32_token_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // ch[7:0]
    input  logic                             s_axis_tlast,  // last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[2:0], version[6:3], action[10:7], minutes[21:11], day_index[37:22],
    // nonce[62:38], mac[62+MAC_WIDTH:63], zero padding above
    output logic [b32td_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [15:0]                      i_cfg_data
);

    // config registers
    logic [15:0] r_cfg_day;
    logic [15:0] r_cfg_max_add;
    logic [10:0] r_cfg_tok_max;
    logic [3:0]  r_cfg_action;

    // token accumulator
    logic [b32td_pkg::TOKEN_BITS-1:0] r_tok, n_tok;
    logic [b32td_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                             r_bad, n_bad;

    // finished token snapshot
    logic                             r_fin_vld;
    logic [b32td_pkg::TOKEN_BITS-1:0] r_snap_tok;
    logic                             r_snap_ok;

    // output register
    logic                             r_out_vld;
    b32td_pkg::t_status               r_out_status, n_out_status;
    logic [3:0]                       r_out_version, n_out_version;
    logic [3:0]                       r_out_action, n_out_action;
    logic [10:0]                      r_out_minutes, n_out_minutes;
    logic [15:0]                      r_out_day, n_out_day;
    logic [24:0]                      r_out_nonce, n_out_nonce;
    logic [b32td_pkg::MAC_WIDTH-1:0]  r_out_mac, n_out_mac;

    logic                             in_acc;
    logic                             out_free;
    logic                             is_sep;
    b32td_pkg::t_sym                  sym;
    logic [b32td_pkg::PAYLOAD_BITS-1:0] payload;
    logic [3:0]                       p_version;
    logic [3:0]                       p_action;
    logic [10:0]                      p_minutes;
    logic [15:0]                      p_day;
    logic [24:0]                      p_nonce;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_fin_vld || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_day     <= 16'd0;
            r_cfg_max_add <= 16'd0;
            r_cfg_tok_max <= 11'd2047;
            r_cfg_action  <= 4'd1;
        end else if (i_cfg_we) begin
            case (b32td_pkg::t_cfg_idx'(i_cfg_idx))
                b32td_pkg::CFG_CURRENT_DAY:   r_cfg_day     <= i_cfg_data;
                b32td_pkg::CFG_MAX_ADD_MIN:   r_cfg_max_add <= i_cfg_data;
                b32td_pkg::CFG_TOKEN_MAX_MIN: r_cfg_tok_max <= i_cfg_data[10:0];
                b32td_pkg::CFG_ACCEPT_ACTION: r_cfg_action  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // character decode and shift
    always_comb begin
        sym = b32td_pkg::sym_decode(s_axis_tdata);
        case (s_axis_tdata) inside
            8'h2d, 8'h20, 8'h09, 8'h0d, 8'h0a: is_sep = 1'b1;
            default:                           is_sep = 1'b0;
        endcase
        n_tok = r_tok;
        n_cnt = r_cnt;
        n_bad = r_bad;
        if (!is_sep) begin
            // extra symbols are flagged, not stored; after an error nothing shifts
            if (!sym.valid || r_cnt == b32td_pkg::CNT_W'(b32td_pkg::SYMBOLS)) begin
                n_bad = 1'b1;
            end else if (!r_bad) begin
                n_tok = {r_tok[b32td_pkg::TOKEN_BITS-6:0], sym.value};
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_cnt <= '0;
            r_bad <= 1'b0;
        end else if (in_acc) begin
            if (s_axis_tlast) begin
                r_tok <= '0;
                r_cnt <= '0;
                r_bad <= 1'b0;
            end else begin
                r_tok <= n_tok;
                r_cnt <= n_cnt;
                r_bad <= n_bad;
            end
        end
    end

    // snapshot of a finished token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (in_acc && s_axis_tlast) begin
            r_fin_vld <= 1'b1;
        end else if (out_free) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tlast) begin
            r_snap_tok <= n_tok;
            r_snap_ok  <= !n_bad && (n_cnt == b32td_pkg::CNT_W'(b32td_pkg::SYMBOLS));
        end
    end

    // unpack and check
    assign payload   = r_snap_tok[b32td_pkg::MAC_WIDTH +: b32td_pkg::PAYLOAD_BITS];
    assign p_nonce   = payload[24:0];
    assign p_day     = payload[40:25];
    assign p_minutes = payload[51:41];
    assign p_action  = payload[55:52];
    assign p_version = payload[59:56];

    always_comb begin
        n_out_status  = b32td_pkg::ST_BAD_CODE;
        n_out_version = 4'd0;
        n_out_action  = 4'd0;
        n_out_minutes = 11'd0;
        n_out_day     = 16'd0;
        n_out_nonce   = 25'd0;
        n_out_mac     = '0;
        if (r_snap_ok) begin
            n_out_version = p_version;
            n_out_action  = p_action;
            n_out_minutes = p_minutes;
            n_out_day     = p_day;
            n_out_nonce   = p_nonce;
            n_out_mac     = r_snap_tok[b32td_pkg::MAC_WIDTH-1:0];
            if (p_version != b32td_pkg::TOKEN_VERSION) begin
                n_out_status = b32td_pkg::ST_BAD_VERSION;
            end else if (p_action != r_cfg_action) begin
                n_out_status = b32td_pkg::ST_BAD_ACTION;
            end else if (p_minutes == 11'd0 || p_minutes > r_cfg_tok_max) begin
                n_out_status = b32td_pkg::ST_BAD_CODE;
            end else if (p_day != r_cfg_day) begin
                n_out_status = b32td_pkg::ST_WRONG_DATE;
            end else if ({5'd0, p_minutes} > r_cfg_max_add) begin
                n_out_status = b32td_pkg::ST_MINUTES_LIMIT;
            end else begin
                n_out_status = b32td_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_fin_vld) begin
            r_out_status  <= n_out_status;
            r_out_version <= n_out_version;
            r_out_action  <= n_out_action;
            r_out_minutes <= n_out_minutes;
            r_out_day     <= n_out_day;
            r_out_nonce   <= n_out_nonce;
            r_out_mac     <= n_out_mac;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = b32td_pkg::OUT_W'({r_out_mac, r_out_nonce, r_out_day, r_out_minutes,
                                              r_out_action, r_out_version, r_out_status});

    // symbol count never passes the token length
    `B32TD_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= b32td_pkg::CNT_W'(b32td_pkg::SYMBOLS))
    // a last character leaves a clean accumulator
    `B32TD_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, in_acc && s_axis_tlast,
        r_cnt == '0 && !r_bad && r_tok == '0)
    // a waiting snapshot moves to the output when it is free
    `B32TD_ASSERT_NXT(a_snap_moves, i_clk, i_rst_n, r_fin_vld && out_free, r_out_vld)
    // an ok status carries nonzero minutes within the max-add limit
    `B32TD_ASSERT_IMP(a_ok_minutes, i_clk, i_rst_n,
        r_out_vld && r_out_status == b32td_pkg::ST_OK,
        r_out_minutes != 11'd0 && 16'(r_out_minutes) <= r_cfg_max_add)

endmodule

### tb/b32td_checker.sv
// Scoreboard for the base32 token decoder: watches the character, result and
// config ports, predicts each result word and compares it. Needs b32td_pkg.
`timescale 1ns / 1ps

module b32td_checker
    import b32td_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // ch[7:0]
    input  logic             s_axis_tlast,   // last
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, version, action, minutes, day_index, nonce, mac (lowest first)
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        t_status                status;
        logic [3:0]             version;
        logic [3:0]             action;
        logic [10:0]            minutes;
        logic [15:0]            day;
        logic [24:0]            nonce;
        logic [MAC_WIDTH-1:0]   mac;
    } t_token_result;

    t_token_result          results_due[$];
    t_token_result          want;
    t_token_result          seen;
    logic [TOKEN_BITS-1:0]  shift_acc;
    int                     sym_count;
    logic                   bad_seen;
    logic [15:0]            day_reg;
    logic [15:0]            max_add_reg;
    logic [10:0]            max_min_reg;
    logic [3:0]             action_reg;
    int                     fails = 0;

    // Crockford value of a character, -1 when it is not a symbol
    function automatic int symbol_of(logic [7:0] c);
        string      alphabet;
        logic [7:0] uc;
        alphabet = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
        uc = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (uc == "O") return 0;
        if (uc == "I" || uc == "L") return 1;
        for (int i = 0; i < 32; i++) begin
            if (alphabet[i] == uc) return i;
        end
        return -1;
    endfunction

    function automatic bit is_gap(logic [7:0] c);
        return c inside {"-", " ", 8'h09, 8'h0d, 8'h0a};
    endfunction

    task automatic clear_token();
        shift_acc = '0;
        sym_count = 0;
        bad_seen  = 1'b0;
    endtask

    task automatic take_char(logic [7:0] c, logic last);
        int                       v;
        t_token_result            r;
        logic [PAYLOAD_BITS-1:0]  payload;
        if (!is_gap(c)) begin
            v = symbol_of(c);
            // an extra symbol is not stored, only flagged
            if (v < 0 || sym_count >= SYMBOLS) begin
                bad_seen = 1'b1;
            end else if (!bad_seen) begin
                shift_acc = {shift_acc[TOKEN_BITS-6:0], 5'(v)};
                sym_count++;
            end
        end
        if (last) begin
            r = '0;
            r.status = ST_OK;
            if (bad_seen || sym_count != SYMBOLS) begin
                r.status = ST_BAD_CODE;
            end else begin
                r.mac   = shift_acc[MAC_WIDTH-1:0];
                payload = shift_acc[MAC_WIDTH +: PAYLOAD_BITS];
                {r.version, r.action, r.minutes, r.day, r.nonce} = payload;
                if (r.version != TOKEN_VERSION)
                    r.status = ST_BAD_VERSION;
                else if (r.action != action_reg)
                    r.status = ST_BAD_ACTION;
                else if (r.minutes == 0 || r.minutes > max_min_reg)
                    r.status = ST_BAD_CODE;
                else if (r.day != day_reg)
                    r.status = ST_WRONG_DATE;
                else if (r.minutes > max_add_reg)
                    r.status = ST_MINUTES_LIMIT;
            end
            results_due.push_back(r);
            clear_token();
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_token();
            results_due.delete();
            day_reg     = '0;
            max_add_reg = '0;
            max_min_reg = 11'd2047;
            action_reg  = 4'd1;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CURRENT_DAY:   day_reg     = i_cfg_data;
                    CFG_MAX_ADD_MIN:   max_add_reg = i_cfg_data;
                    CFG_TOKEN_MAX_MIN: max_min_reg = i_cfg_data[10:0];
                    CFG_ACCEPT_ACTION: action_reg  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_char(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no token pending");
                    fails++;
                end else begin
                    want         = results_due.pop_front();
                    seen.status  = t_status'(m_axis_tdata[2:0]);
                    seen.version = m_axis_tdata[6:3];
                    seen.action  = m_axis_tdata[10:7];
                    seen.minutes = m_axis_tdata[21:11];
                    seen.day     = m_axis_tdata[37:22];
                    seen.nonce   = m_axis_tdata[62:38];
                    seen.mac     = m_axis_tdata[62+MAC_WIDTH:63];
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("version", 32'(want.version), 32'(seen.version));
                    check_field("action", 32'(want.action), 32'(seen.action));
                    check_field("minutes", 32'(want.minutes), 32'(seen.minutes));
                    check_field("day_index", 32'(want.day), 32'(seen.day));
                    check_field("nonce", 32'(want.nonce), 32'(seen.nonce));
                    check_field("mac", 32'(want.mac), 32'(seen.mac));
                end
            end
        end
        o_pending    <= results_due.size();
        o_fail_count <= fails;
    end

endmodule

### tb/tb_top.sv
// Top of the base32 token decoder bench: clock, reset, token stimulus and config
// phases, verdict. Needs b32td_pkg, b32td_checker and base32_token_decoder.
`timescale 1ns / 1ps

module tb_top;
    import b32td_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 9;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;     // ch[7:0]
    logic             s_axis_tlast  = 1'b0;   // last
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // status, version, action, minutes, day_index, nonce, mac (lowest first)
    logic [OUT_W-1:0] m_axis_tdata;
    logic             i_cfg_we      = 1'b0;
    logic [1:0]       i_cfg_idx     = '0;
    logic [15:0]      i_cfg_data    = '0;

    int               pending;
    int               fail_count;
    int               cycles        = 0;
    int               data_chars    = 0;
    bit               steady        = 1'b0;   // no idling on either side

    // bench copy of the registers, used to bias token fields
    logic [15:0]      day_cfg       = '0;
    logic [15:0]      max_add_cfg   = '0;
    logic [10:0]      max_min_cfg   = 11'd2047;
    logic [3:0]       action_cfg    = 4'd1;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    base32_token_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    b32td_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // one symbol, spelled in upper or lower case, with the O/I/L aliases
    function automatic logic [7:0] sym_char(logic [4:0] v);
        string      alphabet;
        logic [7:0] c;
        alphabet = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
        c = alphabet[v];
        if (v == 5'd0 && $urandom_range(0, 2) == 0) c = "O";
        if (v == 5'd1) begin
            case ($urandom_range(0, 2))
                0: c = "I";
                1: c = "L";
                default: ;
            endcase
        end
        if (c >= "A" && $urandom_range(0, 1) == 1) c = c + 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] gap_char();
        case ($urandom_range(0, 4))
            0: return "-";
            1: return " ";
            2: return 8'h09;
            3: return 8'h0d;
            default: return 8'h0a;
        endcase
    endfunction

    // characters that are neither separators nor symbols
    function automatic logic [7:0] bad_char();
        case ($urandom_range(0, 6))
            0: return 8'($urandom_range(8'h80, 8'hff));
            1: return "U";
            2: return "u";
            3: return 8'($urandom_range(8'h01, 8'h08));
            4: return 8'($urandom_range(8'h21, 8'h2c));
            5: return 8'($urandom_range(8'h3a, 8'h40));
            default: return 8'($urandom_range(8'h5b, 8'h60));
        endcase
    endfunction

    // mostly well-formed field values, steered toward the current registers
    function automatic logic [TOKEN_BITS-1:0] make_token();
        logic [3:0]  ver;
        logic [3:0]  act;
        logic [10:0] mins;
        logic [15:0] day;
        ver = ($urandom_range(0, 99) < 85) ? TOKEN_VERSION : 4'($urandom);
        act = ($urandom_range(0, 99) < 85) ? action_cfg : 4'($urandom);
        day = ($urandom_range(0, 99) < 85) ? day_cfg : 16'($urandom);
        case ($urandom_range(0, 9))
            0: mins = '0;
            1: mins = max_min_cfg;
            2: mins = max_min_cfg + 11'd1;
            3: mins = 11'($urandom);
            4: mins = (max_add_cfg > 16'd2047) ? 11'($urandom) : max_add_cfg[10:0];
            5: mins = (max_add_cfg > 16'd2046) ? 11'($urandom) : max_add_cfg[10:0] + 11'd1;
            default: mins = 11'($urandom_range(1, max_min_cfg));
        endcase
        return {ver, act, mins, day, 25'($urandom), MAC_WIDTH'($urandom)};
    endfunction

    task automatic send_word(input logic [7:0] c, input logic last);
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // nsym symbols taken from tok (random past the end), separators sprinkled
    // in, optionally one bad character at a random spot
    task automatic send_token(input logic [TOKEN_BITS-1:0] tok, input int nsym,
                              input bit with_bad);
        logic [7:0] text[$];
        int         bad_pos;
        logic [4:0] v;
        bad_pos = with_bad ? $urandom_range(0, nsym) : -1;
        for (int i = 0; i <= nsym; i++) begin
            if (i == bad_pos) text.push_back(bad_char());
            if (i == nsym) break;
            if ($urandom_range(0, 99) < 15) text.push_back(gap_char());
            v = (i < SYMBOLS) ? tok[TOKEN_BITS-5*(i+1) +: 5] : 5'($urandom);
            text.push_back(sym_char(v));
        end
        if ($urandom_range(0, 4) == 0) text.push_back(gap_char());
        foreach (text[k]) send_word(text[k], k == text.size() - 1);
        data_chars += nsym + int'(with_bad);
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++) send_word(8'($urandom_range(1, 255)), k == len - 1);
        data_chars += len;
    endtask

    // stop sending and wait out every outstanding result word
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] day, input logic [15:0] add,
                              input logic [10:0] mmax, input logic [3:0] act);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CURRENT_DAY;
        i_cfg_data <= day;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_ADD_MIN;
        i_cfg_data <= add;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOKEN_MAX_MIN;
        i_cfg_data <= 16'(mmax);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACCEPT_ACTION;
        i_cfg_data <= 16'(act);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        day_cfg     = day;
        max_add_cfg = add;
        max_min_cfg = mmax;
        action_cfg  = act;
    endtask

    task automatic run_phase(input int min_chars, input int min_tokens);
        int tokens;
        int start;
        int r;
        int n;
        tokens = 0;
        start  = data_chars;
        while (data_chars - start < min_chars || tokens < min_tokens) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_token(make_token(), SYMBOLS, 1'b0);
            end else if (r < 80) begin
                // short or overlong token
                n = ($urandom_range(0, 1) == 1) ? $urandom_range(1, SYMBOLS - 1)
                                                : $urandom_range(SYMBOLS + 1, SYMBOLS + 3);
                send_token(make_token(), n, 1'b0);
            end else if (r < 90) begin
                send_token(make_token(), SYMBOLS, 1'b1);
            end else begin
                send_noise();
            end
            tokens++;
            if ($urandom_range(0, 29) == 0) drain_results();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values; lone bad char, empty token, symbol after error
        send_word("U", 1'b1);
        send_word(8'h09, 1'b1);
        send_word(8'hff, 1'b0);
        send_word("0", 1'b1);
        send_token({TOKEN_VERSION, 4'd1, 11'h7ff, 16'h0000, 25'h1ffffff,
                    {MAC_WIDTH{1'b1}}}, SYMBOLS, 1'b0);
        run_phase(56, 3);

        set_config(16'h0000, 16'h0000, 11'd1, 4'd0);
        run_phase(56, 3);

        set_config(16'hffff, 16'hffff, 11'd2047, 4'd15);
        steady <= 1'b1;
        run_phase(56, 3);
        steady <= 1'b0;

        set_config(16'($urandom), 16'($urandom_range(0, 2047)),
                   11'($urandom_range(1, 2047)), 4'($urandom));
        run_phase(56, 3);

        set_config(16'($urandom), 16'($urandom), 11'($urandom_range(1, 2047)),
                   4'($urandom));
        run_phase(56, 3);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
